// ===== sv/aftm_pkg.sv =====
// ----------------------------------------------------------------------------
// aftm_pkg: shared constants of the ACES fitted tone mapper
// Fixed-point matrix coefficients and fit constants, pipeline layout.
// ----------------------------------------------------------------------------
`default_nettype none

package aftm_pkg;

    localparam int CHANNELS  = 3;
    localparam int IN_W      = 24;   // Q8.16 input channel
    localparam int OUT_W     = 16;   // Q0.16 output channel
    localparam int DIV_STEPS = 17;   // quotient bits, quotient stays below 2^17

    // Fit constants
    localparam logic [10:0] FIT_A16 = 11'd1611;
    localparam logic [18:0] FIT_B32 = 19'd388853;
    localparam logic [15:0] FIT_C16 = 16'd64470;
    localparam logic [14:0] FIT_D16 = 15'd28374;
    localparam logic [29:0] FIT_E32 = 30'd1022550109;

    localparam logic [OUT_W-1:0] UNORM_MAX = 16'hFFFF;

    // Input matrix, row-vector convention: out[j] = sum_i in[i] * MAT_IN[i][j]
    localparam logic [15:0] MAT_IN [CHANNELS][CHANNELS] = '{
        '{16'd39137, 16'd4981,  16'd1861},
        '{16'd23238, 16'd59529, 16'd8771},
        '{16'd3161,  16'd1026,  16'd54904}
    };

    // Output matrix, same convention
    localparam logic signed [17:0] MAT_OUT [CHANNELS][CHANNELS] = '{
        '{ 18'sd105169, -18'sd6690,  -18'sd214  },
        '{-18'sd34805,   18'sd72622, -18'sd4768 },
        '{-18'sd4828,   -18'sd396,    18'sd70518}
    };

endpackage

`default_nettype wire

// ===== sv/aftm_if.sv =====
// ----------------------------------------------------------------------------
// aftm_if: pixel channels of the ACES fitted tone mapper
// HDR request channel and tone-mapped result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface aftm_hdr_if;
    logic        valid;
    logic        ready;
    logic [23:0] red_in;
    logic [23:0] green_in;
    logic [23:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface aftm_ldr_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/aces_fitted_tone_map.sv =====
// ----------------------------------------------------------------------------
// aces_fitted_tone_map: ACES fitted tone mapper, one pixel per clock
// Input matrix, rational fit with pipelined divider, output matrix, clamp.
// ----------------------------------------------------------------------------
// Takes one HDR pixel per clock (three unsigned Q8.16 channels) and returns
// one tone-mapped pixel (three unsigned Q0.16 channels, 65535 = 1.0). The
// datapath is a 26-stage pipeline: input matrix products and sum, the fit
// numerator and denominator over four stages, a restoring divider with one
// quotient bit per stage (17 stages), sign fix, output matrix products and
// the final sum with clamp. Throughput is one pixel per cycle while the
// receiver takes every result. Each stage carries a valid bit and
// stalls only when it is full and the stage after it cannot take its data,
// so bubbles are squeezed out and a new request is taken while finished
// results wait at the output. No reset sequence; the block is ready after
// reset release.
`default_nettype none

module aces_fitted_tone_map (
    input  wire logic clk,
    input  wire logic rst_n,
    aftm_hdr_if.sink  hdr,
    aftm_ldr_if.source ldr
);

    localparam int NC      = aftm_pkg::CHANNELS;
    localparam int NDIV    = aftm_pkg::DIV_STEPS;
    localparam int ST_DIV0 = 5;
    localparam int ST_Q    = ST_DIV0 + NDIV + 1;
    localparam int ST_PROD = ST_Q + 1;
    localparam int NS      = ST_PROD + 2;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    // stage enables: a stage loads when empty or when its successor loads
    always_comb
    begin
        en[NS-1] = !vld_reg[NS-1] || ldr.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign hdr.ready = en[0];
    assign ldr.valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= hdr.valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    logic [23:0] px [NC];
    assign px[0] = hdr.red_in;
    assign px[1] = hdr.green_in;
    assign px[2] = hdr.blue_in;

    // payload registers
    logic        [39:0] s0_prod_reg [NC][NC];
    logic        [23:0] s1_v_reg    [NC];
    logic        [48:0] s2_sq_reg   [NC];
    logic        [40:0] s2_tp_reg   [NC];
    logic        [23:0] s2_v_reg    [NC];
    logic signed [49:0] s3_n_reg    [NC];
    logic        [23:0] s3_t_reg    [NC];
    logic        [23:0] s3_v_reg    [NC];
    logic        [48:0] s4_dm_reg   [NC];
    logic signed [49:0] s4_n_reg    [NC];
    logic        [62:0] dv_rem_reg  [NDIV+1][NC];
    logic        [45:0] dv_dq_reg   [NDIV+1][NC];
    logic        [16:0] dv_quo_reg  [NDIV+1][NC];
    logic               dv_neg_reg  [NDIV+1][NC];
    logic signed [17:0] q_reg       [NC];
    logic signed [35:0] op_reg      [NC][NC];
    logic        [15:0] res_reg     [NC];

    // input matrix products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < NC; i++)
            begin
                for (int j = 0; j < NC; j++)
                begin
                    s0_prod_reg[i][j] <= 40'(px[i]) * 40'(aftm_pkg::MAT_IN[i][j]);
                end
            end
        end
    end

    // sum and round to Q.16
    always_ff @(posedge clk)
    begin
        logic [41:0] sum;
        if (en[1])
        begin
            for (int j = 0; j < NC; j++)
            begin
                sum = 42'(s0_prod_reg[0][j]) + 42'(s0_prod_reg[1][j])
                    + 42'(s0_prod_reg[2][j]) + 42'd32768;
                s1_v_reg[j] <= sum[39:16];
            end
        end
    end

    // numerator square term and denominator scale product
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int j = 0; j < NC; j++)
            begin
                s2_sq_reg[j] <= 49'(s1_v_reg[j])
                              * 49'(25'(s1_v_reg[j]) + 25'(aftm_pkg::FIT_A16));
                s2_tp_reg[j] <= 41'(s1_v_reg[j]) * 41'(aftm_pkg::FIT_C16);
                s2_v_reg[j]  <= s1_v_reg[j];
            end
        end
    end

    // numerator offset, denominator round
    always_ff @(posedge clk)
    begin
        logic [41:0] tr;
        if (en[3])
        begin
            for (int j = 0; j < NC; j++)
            begin
                tr = 42'(s2_tp_reg[j]) + 42'd32768;
                s3_n_reg[j] <= $signed({1'b0, s2_sq_reg[j]})
                             - $signed(50'(aftm_pkg::FIT_B32));
                s3_t_reg[j] <= tr[39:16];
                s3_v_reg[j] <= s2_v_reg[j];
            end
        end
    end

    // denominator product
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int j = 0; j < NC; j++)
            begin
                s4_dm_reg[j] <= 49'(s3_v_reg[j])
                              * 49'(25'(s3_t_reg[j]) + 25'(aftm_pkg::FIT_D16));
                s4_n_reg[j]  <= s3_n_reg[j];
            end
        end
    end

    // divider setup: magnitude, sign, divisor
    always_ff @(posedge clk)
    begin
        logic [49:0] den;
        logic [49:0] mag;
        if (en[ST_DIV0])
        begin
            for (int j = 0; j < NC; j++)
            begin
                den = 50'(s4_dm_reg[j]) + 50'(aftm_pkg::FIT_E32);
                mag = s4_n_reg[j][49] ? 50'(-s4_n_reg[j]) : 50'(s4_n_reg[j]);
                dv_rem_reg[0][j] <= {1'b0, mag, 12'd0};
                dv_dq_reg[0][j]  <= den[49:4];
                dv_quo_reg[0][j] <= '0;
                dv_neg_reg[0][j] <= s4_n_reg[j][49];
            end
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar s = 0; s < NDIV; s++)
    begin : g_div
        localparam int BIT = NDIV - 1 - s;
        always_ff @(posedge clk)
        begin
            logic [62:0] trial;
            if (en[ST_DIV0 + s + 1])
            begin
                for (int j = 0; j < NC; j++)
                begin
                    trial = 63'(dv_dq_reg[s][j]) << BIT;
                    dv_dq_reg[s+1][j]  <= dv_dq_reg[s][j];
                    dv_neg_reg[s+1][j] <= dv_neg_reg[s][j];
                    if (dv_rem_reg[s][j] >= trial)
                    begin
                        dv_rem_reg[s+1][j] <= dv_rem_reg[s][j] - trial;
                        dv_quo_reg[s+1][j] <= dv_quo_reg[s][j] | (17'd1 << BIT);
                    end
                    else
                    begin
                        dv_rem_reg[s+1][j] <= dv_rem_reg[s][j];
                        dv_quo_reg[s+1][j] <= dv_quo_reg[s][j];
                    end
                end
            end
        end
    end

    // apply sign of the numerator
    always_ff @(posedge clk)
    begin
        if (en[ST_Q])
        begin
            for (int j = 0; j < NC; j++)
            begin
                q_reg[j] <= dv_neg_reg[NDIV][j] ? -$signed({1'b0, dv_quo_reg[NDIV][j]})
                                                :  $signed({1'b0, dv_quo_reg[NDIV][j]});
            end
        end
    end

    // output matrix products
    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            for (int i = 0; i < NC; i++)
            begin
                for (int j = 0; j < NC; j++)
                begin
                    op_reg[i][j] <= 36'(q_reg[i]) * 36'(aftm_pkg::MAT_OUT[i][j]);
                end
            end
        end
    end

    // output sum, round, clamp to [0,1]
    always_ff @(posedge clk)
    begin
        logic signed [38:0] sum;
        logic signed [38:0] r;
        if (en[NS-1])
        begin
            for (int j = 0; j < NC; j++)
            begin
                sum = 39'(op_reg[0][j]) + 39'(op_reg[1][j]) + 39'(op_reg[2][j]);
                r   = (sum + 39'sd32768) >>> 16;
                if (sum <= 39'sd0)
                begin
                    res_reg[j] <= '0;
                end
                else if (r > 39'sd65535)
                begin
                    res_reg[j] <= aftm_pkg::UNORM_MAX;
                end
                else
                begin
                    res_reg[j] <= r[15:0];
                end
            end
        end
    end

    assign ldr.red_out   = res_reg[0];
    assign ldr.green_out = res_reg[1];
    assign ldr.blue_out  = res_reg[2];

endmodule

`default_nettype wire

// ===== dv/aftm_checker.sv =====
// ----------------------------------------------------------------------------
// aftm_checker: result checker of the ACES fitted tone mapper
// Watches both pixel channels, predicts each tone-mapped pixel and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module aftm_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    aftm_hdr_if.sink  hdr,
    aftm_ldr_if.sink  ldr,
    output int        fail_count,
    output int        pending
);

    typedef struct packed {
        logic [aftm_pkg::OUT_W-1:0] red;
        logic [aftm_pkg::OUT_W-1:0] green;
        logic [aftm_pkg::OUT_W-1:0] blue;
    } ldr_pixel_t;

    ldr_pixel_t tone_queue[$];

    localparam longint IN_COEF [3][3] = '{
        '{39137, 4981, 1861}, '{23238, 59529, 8771}, '{3161, 1026, 54904}};
    localparam longint OUT_COEF [3][3] = '{
        '{105169, -6690, -214}, '{-34805, 72622, -4768}, '{-4828, -396, 70518}};

    function automatic longint rational_fit(longint v);
        longint num;
        longint t;
        longint den;
        longint mag;
        longint q;
        num = v * (v + 1611) - 64'sd388853;
        t   = (64'sd64470 * v + 32768) >>> 16;
        den = v * (t + 28374) + 64'sd1022550109;
        mag = (num < 0) ? -num : num;
        q   = (mag <<< 12) / (den >>> 4);
        return (num < 0) ? -q : q;
    endfunction

    function automatic ldr_pixel_t tone_map(logic [23:0] r, logic [23:0] g, logic [23:0] b);
        longint px[3];
        longint fit[3];
        longint s;
        longint u;
        logic [15:0] ch[3];
        px[0] = longint'(r);
        px[1] = longint'(g);
        px[2] = longint'(b);
        for (int j = 0; j < 3; j++)
        begin
            s = 0;
            for (int i = 0; i < 3; i++)
                s += px[i] * IN_COEF[i][j];
            fit[j] = rational_fit((s + 32768) >>> 16);
        end
        for (int j = 0; j < 3; j++)
        begin
            s = 0;
            for (int i = 0; i < 3; i++)
                s += fit[i] * OUT_COEF[i][j];
            if (s <= 0)
                ch[j] = '0;
            else
            begin
                u = (s + 32768) >>> 16;
                ch[j] = (u > 65535) ? aftm_pkg::UNORM_MAX : u[15:0];
            end
        end
        return '{red: ch[0], green: ch[1], blue: ch[2]};
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial fail_count = 0;
    initial pending = 0;

    always @(posedge clk)
    begin
        ldr_pixel_t want;
        if (rst_n)
        begin
            if (hdr.valid && hdr.ready)
                tone_queue.push_back(tone_map(hdr.red_in, hdr.green_in, hdr.blue_in));
            if (ldr.valid && ldr.ready)
            begin
                if (tone_queue.size() == 0)
                    report("unexpected result", 0, 0);
                else
                begin
                    want = tone_queue.pop_front();
                    if (ldr.red_out !== want.red)
                        report("red_out", int'(ldr.red_out), int'(want.red));
                    if (ldr.green_out !== want.green)
                        report("green_out", int'(ldr.green_out), int'(want.green));
                    if (ldr.blue_out !== want.blue)
                        report("blue_out", int'(ldr.blue_out), int'(want.blue));
                end
            end
            pending = tone_queue.size();
        end
    end
endmodule

`default_nettype wire

// ===== dv/aces_fitted_tone_map_tb.sv =====
// ----------------------------------------------------------------------------
// aces_fitted_tone_map_tb: testbench of the ACES fitted tone mapper
// Directed and random HDR pixels in bursts against a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module aces_fitted_tone_map_tb;
    localparam int RANDOM_PIXELS = 1300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 60;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;

    aftm_hdr_if hdr ();
    aftm_ldr_if ldr ();

    aces_fitted_tone_map dut (.clk(clk), .rst_n(rst_n), .hdr(hdr.sink), .ldr(ldr.source));

    aftm_checker checker_i (.clk(clk), .rst_n(rst_n), .hdr(hdr.sink), .ldr(ldr.sink),
                            .fail_count(fail_count), .pending(pending));

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: give up if the run hangs.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: stall on its own pattern, with calm stretches of full readiness.
    initial ldr.ready = 1'b0;
    always @(posedge clk)
    begin
        int mode;
        mode = (cycle_count / 300) % 4;
        if (mode == 0)
            ldr.ready <= 1'b1;
        else if (mode == 1)
            ldr.ready <= ($urandom_range(0, 3) != 0);
        else if (mode == 2)
            ldr.ready <= ($urandom_range(0, 1) == 0);
        else
            ldr.ready <= ($urandom_range(0, 7) == 0);
    end

    // Pick a channel value: extremes, small values around the fit's sign change,
    // the range near 1.0, and the full range.
    function automatic logic [23:0] pick_channel();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(0, 64));
            1: return 24'($urandom_range(0, 4096));
            2: return 24'($urandom_range(0, 1 << 18));
            3: return 24'($urandom);
            4: return 24'hFFFFFF - 24'($urandom_range(0, 255));
            default: return 24'($urandom_range(1 << 15, 1 << 17));
        endcase
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b);
        hdr.valid    <= 1'b1;
        hdr.red_in   <= r;
        hdr.green_in <= g;
        hdr.blue_in  <= b;
        @(posedge clk);
        while (!hdr.ready)
            @(posedge clk);
    endtask

    task automatic idle_cycles(int n);
        hdr.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        hdr.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int burst;
        int sent;
        hdr.valid    = 1'b0;
        hdr.red_in   = '0;
        hdr.green_in = '0;
        hdr.blue_in  = '0;
        rst_n        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: black, white, saturating full scale, single channels,
        // tiny values where the fit numerator is negative, near 1.0.
        send_pixel(24'h0, 24'h0, 24'h0);
        send_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(24'hFFFFFF, 24'h0, 24'h0);
        send_pixel(24'h0, 24'hFFFFFF, 24'h0);
        send_pixel(24'h0, 24'h0, 24'hFFFFFF);
        send_pixel(24'd1, 24'd1, 24'd1);
        send_pixel(24'd5, 24'd0, 24'd9);
        send_pixel(24'd16, 24'd16, 24'd16);
        send_pixel(24'h010000, 24'h010000, 24'h010000);
        send_pixel(24'h008000, 24'h004000, 24'h002000);
        send_pixel(24'h020000, 24'h0, 24'h0);
        send_pixel(24'h0, 24'h0, 24'h030000);
        send_pixel(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        send_pixel(24'h555555, 24'hAAAAAA, 24'h555555);
        send_pixel(24'h800000, 24'h7FFFFF, 24'h000001);

        // Hold off until the pipeline empties once.
        wait_drained();

        // Random bursts with gaps; every so often let everything drain.
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst; i++)
                send_pixel(pick_channel(), pick_channel(), pick_channel());
            sent += burst;
            if ($urandom_range(0, 15) == 0)
                wait_drained();
            else if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 12));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire
